// ===== rtl/rttp_pkg.sv =====
// ----------------------------------------------------------------------------
// rttp_pkg
// shared types, result codes and note tables for the ringtone text parser
// ----------------------------------------------------------------------------
package rttp_pkg;

    localparam logic [1:0] K_TONE = 2'd0;
    localparam logic [1:0] K_REST = 2'd1;
    localparam logic [1:0] K_END  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [4:0] REST_MARK = 5'd31;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       song_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [3:0]  semitone;
        logic [3:0]  octave;
        logic [12:0] tone_hz;
        logic [18:0] on_ms;
        logic [19:0] off_ms;
        logic [7:0]  led_pattern;
        logic [10:0] servo_pulse_us;
    } t_out;

    // one note job from the parser to the timing unit
    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [3:0]  semitone;
        logic [3:0]  octave;
        logic [6:0]  length;
        logic [15:0] tempo;
    } t_job;

    // 32 / v for the length settings, 0 above 32
    function automatic logic [5:0] div32(input logic [15:0] v);
        logic [5:0] r;
        priority if (v > 16'd32) r = 6'd0;
        else if (v > 16'd16)     r = 6'd1;
        else if (v > 16'd10)     r = 6'd2;
        else if (v > 16'd8)      r = 6'd3;
        else if (v > 16'd6)      r = 6'd4;
        else if (v == 16'd6)     r = 6'd5;
        else if (v == 16'd5)     r = 6'd6;
        else if (v == 16'd4)     r = 6'd8;
        else if (v == 16'd3)     r = 6'd10;
        else if (v == 16'd2)     r = 6'd16;
        else if (v == 16'd1)     r = 6'd32;
        else                     r = 6'd0;
        return r;
    endfunction

    function automatic logic [12:0] tone_of(input logic [3:0] s);
        logic [12:0] r;
        unique case (s)
            4'd1:    r = 13'd4434;
            4'd2:    r = 13'd4698;
            4'd3:    r = 13'd4978;
            4'd4:    r = 13'd5274;
            4'd5:    r = 13'd5587;
            4'd6:    r = 13'd5919;
            4'd7:    r = 13'd6271;
            4'd8:    r = 13'd6644;
            4'd9:    r = 13'd7040;
            4'd10:   r = 13'd7458;
            4'd11:   r = 13'd7902;
            default: r = 13'd4186;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] led_of(input logic [3:0] s);
        logic [7:0] r;
        unique case (s)
            4'd0:    r = 8'd4;
            4'd1:    r = 8'd16;
            4'd2:    r = 8'd64;
            4'd3:    r = 8'd84;
            4'd4:    r = 8'd3;
            4'd5:    r = 8'd40;
            4'd6:    r = 8'd43;
            4'd7:    r = 8'd68;
            4'd8:    r = 8'd19;
            4'd9:    r = 8'd87;
            4'd10:   r = 8'd124;
            4'd11:   r = 8'd255;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rttp_front.sv =====
// ----------------------------------------------------------------------------
// rttp_front
// byte parser, name/setting/note tokens: if queue not full, one byte per cycle
// ----------------------------------------------------------------------------
module rttp_front import rttp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    localparam logic [2:0] PH_NAME  = 3'd0;
    localparam logic [2:0] PH_SET   = 3'd1;
    localparam logic [2:0] PH_EQ    = 3'd2;
    localparam logic [2:0] PH_VAL   = 3'd3;
    localparam logic [2:0] PH_AFTER = 3'd4;
    localparam logic [2:0] PH_NOTES = 3'd5;
    localparam logic [2:0] PH_IDLE  = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LO    = 8'h6F;

    logic [2:0]  r_ph, n_ph;
    logic [2:0]  r_sub, n_sub;
    logic [5:0]  r_dl, n_dl;
    logic [3:0]  r_doct, n_doct;
    logic [15:0] r_tp, n_tp;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_sl, n_sl;
    logic [4:0]  r_ps, n_ps;
    logic [3:0]  r_po, n_po;
    logic [6:0]  r_pl, n_pl;

    logic       emit;
    t_job       job;
    logic       take;

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;
    assign o_push  = take && emit;
    assign o_job   = job;

    always_comb begin
        logic [7:0]  b;
        logic        dig;
        logic [3:0]  dv;
        logic [19:0] acc10;
        logic        do_start;
        logic        do_letter;
        logic        do_set;
        logic        do_note;
        logic        note_last;
        logic [7:0]  lc;
        logic [7:0]  dot_len;

        b         = i_data.text_byte;
        dig       = (b >= CH_ZERO) && (b <= CH_NINE);
        dv        = 4'(b - CH_ZERO);
        acc10     = 20'd0;
        do_start  = 1'b0;
        do_letter = 1'b0;
        do_set    = 1'b0;
        do_note   = 1'b0;
        note_last = 1'b0;
        lc        = b | 8'h20;
        dot_len   = 8'd0;
        emit      = 1'b0;
        job       = '0;

        if (i_data.song_start) begin
            n_ph = PH_NAME; n_sub = 3'd0; n_dl = 6'd8; n_doct = 4'd6; n_tp = 16'd63;
            n_acc = 16'd0; n_sl = 8'd0; n_ps = REST_MARK; n_po = 4'd6; n_pl = 7'd8;
        end else begin
            n_ph = r_ph; n_sub = r_sub; n_dl = r_dl; n_doct = r_doct; n_tp = r_tp;
            n_acc = r_acc; n_sl = r_sl; n_ps = r_ps; n_po = r_po; n_pl = r_pl;
        end

        if (n_ph >= PH_IDLE) begin
            n_ph = PH_IDLE;
        end else if (n_ph == PH_EQ) begin
            if (b == CH_EQ) begin
                n_acc = 16'd0;
                n_ph  = PH_VAL;
            end else begin
                emit     = 1'b1;
                job.kind = K_ERR;
                job.last = 1'b1;
                n_ph     = PH_IDLE;
            end
        end else if (b == 8'd0) begin
            if (n_ph == PH_NOTES && n_sub >= 3'd2) begin
                do_note   = 1'b1;
                note_last = 1'b1;
            end else begin
                emit     = 1'b1;
                job.kind = K_END;
                job.last = 1'b1;
            end
            n_ph = PH_IDLE;
        end else begin
            unique case (n_ph)
                PH_NAME: begin
                    if (b == CH_COLON) n_ph = PH_SET;
                end
                PH_SET: begin
                    do_set = 1'b1;
                end
                PH_VAL: begin
                    if (dig) begin
                        acc10 = 20'(n_acc) * 20'd10 + 20'(dv);
                        n_acc = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                    end else begin
                        if (n_sl == CH_LD) begin
                            if (n_acc != 16'd0) n_dl = div32(n_acc);
                        end else if (n_sl == CH_LO) begin
                            n_doct = (n_acc > 16'd9) ? 4'd9 : n_acc[3:0];
                        end else if (n_sl == CH_LB) begin
                            n_tp = (n_acc != 16'd0) ? n_acc : 16'd1;
                        end
                        n_ph = PH_AFTER;
                        if (b == CH_COMMA) n_ph = PH_SET;
                        else if (b != CH_SPACE) do_set = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (b == CH_COMMA) n_ph = PH_SET;
                    else if (b != CH_SPACE) do_set = 1'b1;
                end
                default: begin
                    priority if (n_sub == 3'd0) begin
                        do_start = 1'b1;
                    end else if (n_sub == 3'd1) begin
                        if (dig) begin
                            acc10 = 20'(n_acc) * 20'd10 + 20'(dv);
                            n_acc = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
                        end else begin
                            if (n_acc != 16'd0) n_pl = 7'(div32(n_acc));
                            do_letter = 1'b1;
                        end
                    end else if (b == CH_SHARP && n_sub == 3'd2) begin
                        if (n_ps <= 5'd12) n_ps = n_ps + 5'd1;
                        n_sub = 3'd3;
                    end else if (b == CH_LB && (n_sub == 3'd2 || n_sub == 3'd3)) begin
                        if (n_ps == 5'd0) n_ps = REST_MARK;
                        else if (n_ps <= 5'd12) n_ps = n_ps - 5'd1;
                        n_sub = 3'd4;
                    end else if (b == CH_DOT && n_sub >= 3'd2 && n_sub <= 3'd4) begin
                        dot_len = 8'(n_pl) + 8'(n_pl >> 1);
                        n_pl    = dot_len[6:0];
                        n_sub   = 3'd5;
                    end else if (dig && n_sub >= 3'd2 && n_sub <= 3'd5) begin
                        n_po  = dv;
                        n_sub = 3'd6;
                    end else if (b == CH_DOT && (n_sub == 3'd5 || n_sub == 3'd6)) begin
                        dot_len = 8'(n_pl) + 8'(n_pl >> 1);
                        n_pl    = dot_len[6:0];
                        n_sub   = 3'd7;
                    end else if (b == CH_SPACE) begin
                        n_sub = 3'd7;
                    end else begin
                        do_note = 1'b1;
                        if (b == CH_COMMA) n_sub = 3'd0;
                        else do_start = 1'b1;
                    end
                end
            endcase
        end

        // note leaves with the pending values before a new token starts
        if (do_note) begin
            emit         = 1'b1;
            job.last     = note_last;
            job.length   = n_pl;
            job.tempo    = n_tp;
            if (n_ps > 5'd12) begin
                job.kind = K_REST;
            end else begin
                job.kind     = K_TONE;
                job.semitone = n_ps[3:0];
                job.octave   = n_po;
            end
        end

        if (do_set) begin
            if (b == CH_SPACE) begin
                n_ph = PH_SET;
            end else if (b == CH_COLON) begin
                n_ph  = PH_NOTES;
                n_sub = 3'd0;
            end else begin
                n_sl = b;
                n_ph = PH_EQ;
            end
        end

        if (do_start) begin
            n_sub = 3'd0;
            if (b != CH_SPACE) begin
                n_pl  = 7'(n_dl);
                n_po  = n_doct;
                n_ps  = REST_MARK;
                n_acc = 16'd0;
                if (dig) begin
                    n_acc = 16'(dv);
                    n_sub = 3'd1;
                end else begin
                    do_letter = 1'b1;
                end
            end
        end

        if (do_letter) begin
            unique case (lc)
                CH_LC:        n_ps = 5'd0;
                CH_LD:        n_ps = 5'd2;
                CH_LE:        n_ps = 5'd4;
                CH_LF:        n_ps = 5'd5;
                CH_LG:        n_ps = 5'd7;
                CH_LA:        n_ps = 5'd9;
                CH_LH, CH_LB: n_ps = 5'd11;
                default:      n_ps = REST_MARK;
            endcase
            n_sub = 3'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_NAME;
            r_sub  <= 3'd0;
            r_dl   <= 6'd8;
            r_doct <= 4'd6;
            r_tp   <= 16'd63;
            r_acc  <= 16'd0;
            r_sl   <= 8'd0;
            r_ps   <= REST_MARK;
            r_po   <= 4'd6;
            r_pl   <= 7'd8;
        end else if (take) begin
            r_ph   <= n_ph;
            r_sub  <= n_sub;
            r_dl   <= n_dl;
            r_doct <= n_doct;
            r_tp   <= n_tp;
            r_acc  <= n_acc;
            r_sl   <= n_sl;
            r_ps   <= n_ps;
            r_po   <= n_po;
            r_pl   <= n_pl;
        end
    end

endmodule

// ===== rtl/rttp_queue.sv =====
// ----------------------------------------------------------------------------
// rttp_queue
// two-entry job queue between parser and timing unit
// ----------------------------------------------------------------------------
module rttp_queue import rttp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("job queue underflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("job queue count out of range");

endmodule

// ===== rtl/rttp_back.sv =====
// ----------------------------------------------------------------------------
// rttp_back
// note timing: bit-serial length / tempo divider and result formatting
// ----------------------------------------------------------------------------
module rttp_back import rttp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam int NUM_W = 23;

    logic [1:0]       r_state;
    t_job             r_job;
    logic [NUM_W-1:0] r_quo;
    logic [19:0]      r_rem;
    logic [18:0]      r_den;
    logic [4:0]       r_cnt;
    logic             r_valid;
    t_out             r_out;

    logic [19:0] trial;
    logic        fit;
    logic        load_out;
    t_out        res;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign load_out = (r_state == S_FIN) && (!r_valid || i_ready);
    assign trial    = {r_rem[18:0], r_quo[NUM_W-1]};
    assign fit      = trial >= {1'b0, r_den};
    assign o_valid  = r_valid;
    assign o_data   = r_out;

    always_comb begin
        logic [19:0] ms;
        logic        carry;
        logic [4:0]  up;
        logic [3:0]  sh;
        logic [22:0] ms7;

        ms    = r_quo[19:0];
        carry = (r_job.semitone == 4'd12);
        up    = 5'(r_job.octave) + 5'd1 + 5'(carry);
        sh    = (up >= 5'd9) ? 4'd0 : 4'(5'd9 - up);
        ms7   = 23'(ms) * 23'd7;
        res   = '0;
        res.kind = r_job.kind;
        res.last = r_job.last;
        if (r_job.kind == K_TONE) begin
            res.semitone       = r_job.semitone;
            res.octave         = r_job.octave;
            res.tone_hz        = tone_of(carry ? 4'd0 : r_job.semitone) >> sh;
            res.on_ms          = ms7[21:3];
            res.off_ms         = {3'd0, ms[19:3]};
            res.led_pattern    = led_of(r_job.semitone);
            res.servo_pulse_us = 11'd1030 + 11'(r_job.semitone) * 11'd30;
        end else if (r_job.kind == K_REST) begin
            res.off_ms = ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (load_out) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (i_job.kind == K_TONE || i_job.kind == K_REST)
                                   ? S_DIV : S_FIN;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd1) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_quo <= 23'(i_job.length) * 23'd60000;
            r_den <= {((i_job.tempo != 16'd0) ? i_job.tempo : 16'd1), 3'b000};
            r_rem <= 20'd0;
            r_cnt <= 5'(NUM_W);
        end else if (r_state == S_DIV) begin
            r_rem <= fit ? trial - {1'b0, r_den} : trial;
            r_quo <= {r_quo[NUM_W-2:0], fit};
            r_cnt <= r_cnt - 5'd1;
        end
        if (load_out) r_out <= res;
    end

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_out.kind == K_END || r_out.kind == K_ERR) |-> r_out.last)
        else $error("end or error result without last");

    a_rest_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == K_REST |-> r_out.tone_hz == 13'd0 && r_out.on_ms == 19'd0)
        else $error("rest result carries a tone");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < {1'b0, r_den})
        else $error("divider remainder out of range");

endmodule

// ===== rtl/ringtone_text_note_parser.sv =====
// ----------------------------------------------------------------------------
// ringtone_text_note_parser
// ringtone text to note results: parser, job queue and note timing unit
// ----------------------------------------------------------------------------
// Text bytes are taken at one per cycle whenever the two-entry job queue has
// room. A tone or rest result passes through the queue and the bit-serial
// divider (23 steps) that turns length and tempo into milliseconds before
// it reaches the output register; end-of-song and error results skip the
// divider. Results wait in an output register, so parsing continues
// while the consumer stalls until the queue fills.
module ringtone_text_note_parser import rttp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic q_full;
    logic q_push;
    t_job q_in;
    logic q_valid;
    logic q_pop;
    t_job q_out;

    rttp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in)
    );

    rttp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_out)
    );

    rttp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
